FILE: rtl/cpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpq_pkg
// Shared constants, entry type and rank function for the notification
// priority queue.
// ----------------------------------------------------------------------------
package cpq_pkg;

    localparam int DEPTH        = 16;
    localparam int PAYLOAD_BITS = 16;
    localparam int IDX_W        = $clog2(DEPTH);
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int STAMP_W      = 32;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    localparam logic [1:0] TYPE_OTHER   = 2'd0;
    localparam logic [1:0] TYPE_INSTANT = 2'd1;
    localparam logic [1:0] TYPE_SYSTEM  = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam logic [2:0] RANK_OTHER          = 3'd1;
    localparam logic [2:0] RANK_SYSTEM         = 3'd2;
    localparam logic [2:0] RANK_INSTANT        = 3'd3;
    localparam logic [2:0] RANK_SERIOUS_SYSTEM = 3'd4;

    typedef struct packed {
        logic [1:0]              notif_type;
        logic                    serious;
        logic [STAMP_W-1:0]      stamp;
        logic [PAYLOAD_BITS-1:0] payload;
    } entry_t;

    function automatic logic [2:0] rank_of(input entry_t e);
        logic [2:0] r;
        r = RANK_OTHER;
        if (e.notif_type == TYPE_INSTANT)
        begin
            r = RANK_INSTANT;
        end
        else if (e.notif_type == TYPE_SYSTEM)
        begin
            r = e.serious ? RANK_SERIOUS_SYSTEM : RANK_SYSTEM;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/class_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// class_priority_queue
// Bounded priority queue of notification entries with a linear-scan pop.
// ----------------------------------------------------------------------------
// Usage: drive kind and the entry fields with start high while busy is low;
// that edge is the input transfer. busy stays high until the operation ends.
// Each operation gives one result on status, out_* and occupancy, marked by
// done for exactly one cycle; the receiver takes it in that cycle and cannot
// stall it.
// A push to a full store or a pop from an empty store is rejected without a scan
// (done is high in the cycle right after the transfer, and the next transfer
// can be made at the edge that ends it). Otherwise the sequencer walks all
// DEPTH slots through the single comparator, reading the entry memory one
// slot a cycle with a registered read: the scan state issues the reads in
// turn, the compare stage judges each slot from the registered read data,
// and the finish state commits the operation and raises done. A new transfer
// can be made in the cycle done is high.
// A push claims the first free slot found by the scan; a pop returns the most
// urgent valid entry and ages the younger entries.
// Reset empties the store at once (valid bits and count cleared); memory
// contents are not cleared.
// ----------------------------------------------------------------------------
module class_priority_queue
    import cpq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    kind,
    input  logic [1:0]              notif_type,
    input  logic                    serious,
    input  logic [STAMP_W-1:0]      stamp,
    input  logic [PAYLOAD_BITS-1:0] payload,
    output logic                    done,
    output logic [1:0]              status,
    output logic                    out_valid,
    output logic [1:0]              out_type,
    output logic                    out_serious,
    output logic [STAMP_W-1:0]      out_stamp,
    output logic [PAYLOAD_BITS-1:0] out_payload,
    output logic [CNT_W-1:0]        occupancy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    state_t                  state_reg;
    logic                    op_reg;
    entry_t                  in_entry_reg;
    logic [IDX_W-1:0]        addr_reg;
    logic                    issue_done_reg;
    logic                    cmp_valid_reg;
    logic [IDX_W-1:0]        cmp_idx_reg;
    logic                    found_reg;
    logic [IDX_W-1:0]        best_idx_reg;
    logic [IDX_W-1:0]        best_age_reg;
    entry_t                  best_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [DEPTH-1:0]        valid_reg;
    logic [IDX_W-1:0]        order_reg [DEPTH];

    logic                    done_reg;
    logic [1:0]              status_reg;
    logic                    out_valid_reg;
    entry_t                  out_entry_reg;

    entry_t                  mem [DEPTH];
    entry_t                  rd_data_reg;

    logic                    accept;
    logic                    beats;
    logic                    cmp_slot_valid;
    logic [IDX_W-1:0]        cmp_age;
    logic                    mem_we;
    logic                    push_commit;
    logic                    pop_commit;

    assign busy           = state_reg != ST_IDLE;
    assign accept         = start && !busy;
    assign cmp_slot_valid = valid_reg[cmp_idx_reg];
    assign cmp_age        = order_reg[cmp_idx_reg];
    assign push_commit    = state_reg == ST_FINISH && op_reg == KIND_PUSH;
    assign pop_commit     = state_reg == ST_FINISH && op_reg == KIND_POP;
    assign mem_we         = push_commit;

    cpq_compare u_compare (
        .cand     (rd_data_reg),
        .cand_age (cmp_age),
        .best     (best_reg),
        .best_age (best_age_reg),
        .beats    (beats)
    );

    // entry memory, one read port swept by the scan address
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[best_idx_reg] <= in_entry_reg;
        end
        rd_data_reg <= mem[addr_reg];
    end

    // valid bits and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else if (push_commit)
        begin
            valid_reg[best_idx_reg] <= 1'b1;
            count_reg               <= count_reg + CNT_W'(1);
        end
        else if (pop_commit)
        begin
            valid_reg[best_idx_reg] <= 1'b0;
            count_reg               <= count_reg - CNT_W'(1);
        end
    end

    // insertion age, dense among stored entries
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (push_commit && best_idx_reg == IDX_W'(i))
            begin
                order_reg[i] <= count_reg[IDX_W-1:0];
            end
            else if (pop_commit && valid_reg[i] && order_reg[i] > best_age_reg)
            begin
                order_reg[i] <= order_reg[i] - IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= KIND_PUSH;
            in_entry_reg   <= '0;
            addr_reg       <= '0;
            issue_done_reg <= 1'b0;
            cmp_valid_reg  <= 1'b0;
            cmp_idx_reg    <= '0;
            found_reg      <= 1'b0;
            best_idx_reg   <= '0;
            best_age_reg   <= '0;
            best_reg       <= '0;
            done_reg       <= 1'b0;
            status_reg     <= STATUS_OK;
            out_valid_reg  <= 1'b0;
            out_entry_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg                  <= kind;
                        in_entry_reg.notif_type <= notif_type;
                        in_entry_reg.serious    <= serious;
                        in_entry_reg.stamp      <= stamp;
                        in_entry_reg.payload    <= payload;
                        addr_reg                <= '0;
                        issue_done_reg          <= 1'b0;
                        cmp_valid_reg           <= 1'b0;
                        found_reg               <= 1'b0;
                        if (kind == KIND_PUSH && count_reg == FULL_CNT)
                        begin
                            done_reg      <= 1'b1;
                            status_reg    <= STATUS_FULL;
                            out_valid_reg <= 1'b0;
                            out_entry_reg <= '0;
                        end
                        else if (kind == KIND_POP && count_reg == '0)
                        begin
                            done_reg      <= 1'b1;
                            status_reg    <= STATUS_EMPTY;
                            out_valid_reg <= 1'b0;
                            out_entry_reg <= '0;
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    // read issue, one slot a cycle
                    cmp_valid_reg <= !issue_done_reg;
                    cmp_idx_reg   <= addr_reg;
                    if (!issue_done_reg)
                    begin
                        if (addr_reg == LAST_IDX)
                        begin
                            issue_done_reg <= 1'b1;
                        end
                        else
                        begin
                            addr_reg <= addr_reg + IDX_W'(1);
                        end
                    end
                    // compare stage, in the cycle after the read is issued
                    if (cmp_valid_reg)
                    begin
                        if (op_reg == KIND_POP)
                        begin
                            if (cmp_slot_valid && (!found_reg || beats))
                            begin
                                found_reg    <= 1'b1;
                                best_idx_reg <= cmp_idx_reg;
                                best_age_reg <= cmp_age;
                                best_reg     <= rd_data_reg;
                            end
                        end
                        else if (!cmp_slot_valid && !found_reg)
                        begin
                            found_reg    <= 1'b1;
                            best_idx_reg <= cmp_idx_reg;
                        end
                        if (cmp_idx_reg == LAST_IDX)
                        begin
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_FINISH:
                begin
                    done_reg   <= 1'b1;
                    status_reg <= STATUS_OK;
                    if (op_reg == KIND_POP)
                    begin
                        out_valid_reg <= 1'b1;
                        out_entry_reg <= best_reg;
                    end
                    else
                    begin
                        out_valid_reg <= 1'b0;
                        out_entry_reg <= '0;
                    end
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign out_valid   = out_valid_reg;
    assign out_type    = out_entry_reg.notif_type;
    assign out_serious = out_entry_reg.serious;
    assign out_stamp   = out_entry_reg.stamp;
    assign out_payload = out_entry_reg.payload;
    assign occupancy   = count_reg;

    occupancy_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(valid_reg)))
        else $error("occupancy count out of step with valid bits");

    result_only_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == ST_IDLE)
        else $error("result strobe while sequencer busy");

    popped_entry_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && out_valid_reg) |-> status_reg == STATUS_OK)
        else $error("popped entry with error status");

    full_push_rejected: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind == KIND_PUSH && count_reg == FULL_CNT)
        |=> (done_reg && status_reg == STATUS_FULL))
        else $error("push to full store not rejected");

    scan_finds_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> found_reg)
        else $error("scan ended without a slot");

endmodule
`default_nettype wire

FILE: rtl/cpq_compare.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpq_compare
// Shared urgency comparator: rank, then stamp, then insertion age.
// ----------------------------------------------------------------------------
module cpq_compare
    import cpq_pkg::*;
(
    input  entry_t           cand,
    input  logic [IDX_W-1:0] cand_age,
    input  entry_t           best,
    input  logic [IDX_W-1:0] best_age,
    output logic             beats
);

    logic [2:0] cand_rank;
    logic [2:0] best_rank;

    assign cand_rank = rank_of(cand);
    assign best_rank = rank_of(best);

    always_comb
    begin
        if (cand_rank != best_rank)
        begin
            beats = cand_rank > best_rank;
        end
        else if (cand.stamp != best.stamp)
        begin
            beats = cand.stamp < best.stamp;
        end
        else
        begin
            beats = cand_age < best_age;
        end
    end

endmodule
`default_nettype wire
